@@ hw/rtl/esd_pkg.sv @@
package esd_pkg;

  localparam int unsigned Subscribers = 8;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned EventBits   = 8;

  typedef enum logic [2:0] {
    OP_SUBSCRIBE   = 3'd0,
    OP_UNSUBSCRIBE = 3'd1,
    OP_PUBLISH     = 3'd2,
    OP_ENQUEUE     = 3'd3,
    OP_DRAIN       = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    KIND_SUB_ACK   = 3'd0,
    KIND_UNSUB_ACK = 3'd1,
    KIND_DELIVERY  = 3'd2,
    KIND_ENQ_ACK   = 3'd3,
    KIND_DONE      = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SUB_SCAN,
    ST_PUB_SCAN,
    ST_DRAIN_POP,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  event_id;
    logic [7:0]  handle;
    logic [31:0] target;
    logic [31:0] tag;
    logic [31:0] param_a;
    logic [31:0] param_b;
  } req_t;

  typedef struct packed {
    kind_e       kind;
    logic        ok;
    logic [2:0]  slot;
    logic [7:0]  out_event;
    logic [31:0] out_param_a;
    logic [31:0] out_param_b;
    logic [31:0] out_target;
    logic [31:0] out_tag;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic  accept;
    logic  idx_clr;
    logic  idx_inc;
    logic  sub_write;
    logic  unsub;
    logic  enq;
    logic  pop;
    logic  emit;
    kind_e kind;
    logic  ok;
    logic  slot_idx;
    logic  last;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic idx_end;
    logic cur_free;
    logic cur_match;
    logic q_empty;
    logic q_full;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/event_subscription_dispatcher.sv @@
// Publish/subscribe event router with a subscriber table and a pending-event queue.
// Requests enter on in_valid_i/in_ready_o with an esd_pkg::req_t payload; results
// leave on out_valid_o/out_ready_i with an esd_pkg::rsp_t payload, and the last
// result of each request carries last = 1.
// One request is in flight at a time; in_ready_o is high only while the block waits
// for a request. A result appears on the output in the cycle after it is produced.
// Subscribe scans the table slot by slot and takes the first free slot.
// Unsubscribe and enqueue answer without a scan. Publish matches every slot.
// Drain pops each queued event in turn and matches it against every slot, one
// slot per cycle while no matching slot waits on a full output register.
// The single scan index over the subscriber table serves all of these scans.
// When the receiver stalls, the output register holds its result and the scan
// pauses at the next matching slot until the register frees; no result is lost.
// Reset clears the subscriber valid bits, the queue pointers, the queue count
// and the output valid; table and queue entries are written before they are read.
module event_subscription_dispatcher #(
  parameter int unsigned SUBSCRIBERS = esd_pkg::Subscribers,
  parameter int unsigned QUEUE_DEPTH = esd_pkg::QueueDepth,
  parameter int unsigned EVENT_BITS  = esd_pkg::EventBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  esd_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output esd_pkg::rsp_t out_data_o
);

  esd_pkg::cmd_t cmd;
  esd_pkg::sts_t sts;

  esd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  esd_datapath #(
    .SUBSCRIBERS (SUBSCRIBERS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .EVENT_BITS  (EVENT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ hw/rtl/esd_ctrl.sv @@
module esd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  esd_pkg::sts_t sts_i,
  output esd_pkg::cmd_t cmd_o
);

  esd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= esd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.kind = esd_pkg::KIND_DONE;
    case (state_q)
      esd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept  = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = esd_pkg::ST_DISPATCH;
        end
      end
      esd_pkg::ST_DISPATCH: begin
        case (sts_i.op)
          esd_pkg::OP_SUBSCRIBE: state_d = esd_pkg::ST_SUB_SCAN;
          esd_pkg::OP_PUBLISH:   state_d = esd_pkg::ST_PUB_SCAN;
          esd_pkg::OP_DRAIN:     state_d = esd_pkg::ST_DRAIN_POP;
          esd_pkg::OP_UNSUBSCRIBE: begin
            if (sts_i.out_free) begin
              cmd_o.unsub = 1'b1;
              cmd_o.emit  = 1'b1;
              cmd_o.kind  = esd_pkg::KIND_UNSUB_ACK;
              cmd_o.ok    = 1'b1;
              cmd_o.last  = 1'b1;
              state_d     = esd_pkg::ST_IDLE;
            end
          end
          esd_pkg::OP_ENQUEUE: begin
            if (sts_i.out_free) begin
              cmd_o.enq  = !sts_i.q_full;
              cmd_o.emit = 1'b1;
              cmd_o.kind = esd_pkg::KIND_ENQ_ACK;
              cmd_o.ok   = !sts_i.q_full;
              cmd_o.last = 1'b1;
              state_d    = esd_pkg::ST_IDLE;
            end
          end
          default: state_d = esd_pkg::ST_IDLE;
        endcase
      end
      esd_pkg::ST_SUB_SCAN: begin
        if (sts_i.cur_free || sts_i.idx_end) begin
          if (sts_i.out_free) begin
            cmd_o.sub_write = sts_i.cur_free;
            cmd_o.emit      = 1'b1;
            cmd_o.kind      = esd_pkg::KIND_SUB_ACK;
            cmd_o.ok        = sts_i.cur_free;
            cmd_o.slot_idx  = sts_i.cur_free;
            cmd_o.last      = 1'b1;
            state_d         = esd_pkg::ST_IDLE;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      esd_pkg::ST_PUB_SCAN: begin
        if (!sts_i.cur_match || sts_i.out_free) begin
          if (sts_i.cur_match) begin
            cmd_o.emit     = 1'b1;
            cmd_o.kind     = esd_pkg::KIND_DELIVERY;
            cmd_o.ok       = 1'b1;
            cmd_o.slot_idx = 1'b1;
          end
          if (sts_i.idx_end) begin
            state_d = (sts_i.op == esd_pkg::OP_PUBLISH) ? esd_pkg::ST_DONE
                                                         : esd_pkg::ST_DRAIN_POP;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      esd_pkg::ST_DRAIN_POP: begin
        if (sts_i.q_empty) begin
          state_d = esd_pkg::ST_DONE;
        end else begin
          cmd_o.pop     = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = esd_pkg::ST_PUB_SCAN;
        end
      end
      esd_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = esd_pkg::KIND_DONE;
          cmd_o.ok   = 1'b1;
          cmd_o.last = 1'b1;
          state_d    = esd_pkg::ST_IDLE;
        end
      end
      default: state_d = esd_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/esd_datapath.sv @@
module esd_datapath #(
  parameter int unsigned SUBSCRIBERS = esd_pkg::Subscribers,
  parameter int unsigned QUEUE_DEPTH = esd_pkg::QueueDepth,
  parameter int unsigned EVENT_BITS  = esd_pkg::EventBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  esd_pkg::req_t in_data_i,
  input  esd_pkg::cmd_t cmd_i,
  output esd_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output esd_pkg::rsp_t out_data_o
);

  localparam int unsigned IdxW = (SUBSCRIBERS > 1) ? $clog2(SUBSCRIBERS) : 1;
  localparam int unsigned QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(SUBSCRIBERS - 1);
  localparam logic [QW-1:0]   QLast   = QW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] QFull   = CntW'(QUEUE_DEPTH);

  logic [SUBSCRIBERS-1:0] sub_active_q, sub_active_d;
  logic [EVENT_BITS-1:0]  sub_event_q  [SUBSCRIBERS];
  logic [31:0]            sub_target_q [SUBSCRIBERS];
  logic [31:0]            sub_tag_q    [SUBSCRIBERS];

  logic [EVENT_BITS-1:0]  pend_event_q   [QUEUE_DEPTH];
  logic [31:0]            pend_param_a_q [QUEUE_DEPTH];
  logic [31:0]            pend_param_b_q [QUEUE_DEPTH];
  logic [QW-1:0]          head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]        cnt_q, cnt_d;

  esd_pkg::op_e           op_q;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [7:0]             handle_q;
  logic [31:0]            target_q, tag_q;
  logic [EVENT_BITS-1:0]  cur_ev_q;
  logic [31:0]            cur_pa_q, cur_pb_q;

  logic                   out_valid_q, out_valid_d;
  esd_pkg::rsp_t          rsp_q, rsp_d;
  logic                   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.op        = op_q;
    sts_o.idx_end   = (idx_q == IdxLast);
    sts_o.cur_free  = !sub_active_q[idx_q];
    sts_o.cur_match = sub_active_q[idx_q] && (sub_event_q[idx_q] == cur_ev_q) &&
                      (sub_target_q[idx_q] != 32'd0);
    sts_o.q_empty   = (cnt_q == '0);
    sts_o.q_full    = (cnt_q == QFull);
    sts_o.out_free  = out_free;
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + 1'b1;
    end
    sub_active_d = sub_active_q;
    if (cmd_i.sub_write) begin
      sub_active_d[idx_q] = 1'b1;
    end
    if (cmd_i.unsub && (handle_q < 8'(SUBSCRIBERS))) begin
      sub_active_d[handle_q[IdxW-1:0]] = 1'b0;
    end
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (cmd_i.enq) begin
      tail_d = (tail_q == QLast) ? '0 : tail_q + 1'b1;
      cnt_d  = cnt_q + 1'b1;
    end
    if (cmd_i.pop) begin
      head_d = (head_q == QLast) ? '0 : head_q + 1'b1;
      cnt_d  = cnt_q - 1'b1;
    end
    out_valid_d = cmd_i.emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_comb begin
    rsp_d      = '0;
    rsp_d.kind = cmd_i.kind;
    rsp_d.ok   = cmd_i.ok;
    rsp_d.last = cmd_i.last;
    rsp_d.slot = cmd_i.slot_idx ? 3'(idx_q) : 3'd0;
    if (cmd_i.kind == esd_pkg::KIND_DELIVERY) begin
      rsp_d.out_event   = 8'(cur_ev_q);
      rsp_d.out_param_a = cur_pa_q;
      rsp_d.out_param_b = cur_pb_q;
      rsp_d.out_target  = sub_target_q[idx_q];
      rsp_d.out_tag     = sub_tag_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_active_q <= '0;
      idx_q        <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      cnt_q        <= '0;
      op_q         <= esd_pkg::OP_SUBSCRIBE;
      out_valid_q  <= 1'b0;
    end else begin
      sub_active_q <= sub_active_d;
      idx_q        <= idx_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      if (cmd_i.accept) begin
        op_q <= in_data_i.op;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      handle_q <= in_data_i.handle;
      target_q <= in_data_i.target;
      tag_q    <= in_data_i.tag;
      cur_ev_q <= EVENT_BITS'(in_data_i.event_id);
      cur_pa_q <= in_data_i.param_a;
      cur_pb_q <= in_data_i.param_b;
    end else if (cmd_i.pop) begin
      cur_ev_q <= pend_event_q[head_q];
      cur_pa_q <= pend_param_a_q[head_q];
      cur_pb_q <= pend_param_b_q[head_q];
    end
    if (cmd_i.sub_write) begin
      sub_event_q[idx_q]  <= cur_ev_q;
      sub_target_q[idx_q] <= target_q;
      sub_tag_q[idx_q]    <= tag_q;
    end
    if (cmd_i.enq) begin
      pend_event_q[tail_q]   <= cur_ev_q;
      pend_param_a_q[tail_q] <= cur_pa_q;
      pend_param_b_q[tail_q] <= cur_pb_q;
    end
    if (cmd_i.emit) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QFull)
    else $error("queue count above depth");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == tail_q) == (cnt_q == '0 || cnt_q == QFull))
    else $error("queue pointers disagree with count");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxLast)
    else $error("scan index past table");

  a_dlv_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rsp_q.kind == esd_pkg::KIND_DELIVERY |-> !rsp_q.last)
    else $error("delivery marked last");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result overwrites pending result");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 40;
  localparam logic [2:0] OpUnusedLo = 3'd5;
  localparam logic [2:0] OpUnusedHi = 3'd7;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  esd_pkg::req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  esd_pkg::rsp_t out_data_o;

  event_subscription_dispatcher u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  bit          sub_live [esd_pkg::Subscribers];
  logic [7:0]  sub_evt  [esd_pkg::Subscribers];
  logic [31:0] sub_tgt  [esd_pkg::Subscribers];
  logic [31:0] sub_word [esd_pkg::Subscribers];
  int unsigned live_count;
  logic [7:0]  pend_evt [esd_pkg::QueueDepth];
  logic [31:0] pend_a   [esd_pkg::QueueDepth];
  logic [31:0] pend_b   [esd_pkg::QueueDepth];
  int unsigned pend_rd, pend_wr, pend_num;

  esd_pkg::rsp_t rsp_awaited[$];
  int unsigned   error_count;
  int unsigned   cycle_count;
  bit            idle_en = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic esd_pkg::req_t make_req(esd_pkg::op_e op, logic [7:0] ev,
                                             logic [7:0] handle, logic [31:0] target,
                                             logic [31:0] tag, logic [31:0] pa,
                                             logic [31:0] pb);
    esd_pkg::req_t r;
    r.op       = op;
    r.event_id = ev;
    r.handle   = handle;
    r.target   = target;
    r.tag      = tag;
    r.param_a  = pa;
    r.param_b  = pb;
    return r;
  endfunction

  function automatic void push_rsp(esd_pkg::kind_e kind, logic ok, logic [2:0] slot,
                                   logic [7:0] ev, logic [31:0] pa, logic [31:0] pb,
                                   logic [31:0] tgt, logic [31:0] tag, logic last);
    esd_pkg::rsp_t r;
    r.kind        = kind;
    r.ok          = ok;
    r.slot        = slot;
    r.out_event   = ev;
    r.out_param_a = pa;
    r.out_param_b = pb;
    r.out_target  = tgt;
    r.out_tag     = tag;
    r.last        = last;
    rsp_awaited.push_back(r);
  endfunction

  function automatic void fan_out(logic [7:0] ev, logic [31:0] pa, logic [31:0] pb);
    for (int i = 0; i < esd_pkg::Subscribers; i++) begin
      if (sub_live[i] && sub_evt[i] == ev && sub_tgt[i] != '0) begin
        push_rsp(esd_pkg::KIND_DELIVERY, 1'b1, 3'(i), ev, pa, pb, sub_tgt[i],
                 sub_word[i], 1'b0);
      end
    end
  endfunction

  function automatic void route_request(esd_pkg::req_t r);
    logic [7:0] ev;
    int grant;
    ev = r.event_id & 8'((1 << esd_pkg::EventBits) - 1);
    grant = -1;
    case (r.op)
      esd_pkg::OP_SUBSCRIBE: begin
        for (int i = 0; i < esd_pkg::Subscribers; i++) begin
          if (grant < 0 && !sub_live[i]) grant = i;
        end
        if (live_count < esd_pkg::Subscribers && grant >= 0) begin
          sub_live[grant] = 1'b1;
          sub_evt[grant]  = ev;
          sub_tgt[grant]  = r.target;
          sub_word[grant] = r.tag;
          live_count++;
          push_rsp(esd_pkg::KIND_SUB_ACK, 1'b1, 3'(grant), '0, '0, '0, '0, '0, 1'b1);
        end else begin
          push_rsp(esd_pkg::KIND_SUB_ACK, 1'b0, '0, '0, '0, '0, '0, '0, 1'b1);
        end
      end
      esd_pkg::OP_UNSUBSCRIBE: begin
        if (r.handle < esd_pkg::Subscribers && sub_live[r.handle]) begin
          sub_live[r.handle] = 1'b0;
          if (live_count > 0) live_count--;
        end
        push_rsp(esd_pkg::KIND_UNSUB_ACK, 1'b1, '0, '0, '0, '0, '0, '0, 1'b1);
      end
      esd_pkg::OP_PUBLISH: begin
        fan_out(ev, r.param_a, r.param_b);
        push_rsp(esd_pkg::KIND_DONE, 1'b1, '0, '0, '0, '0, '0, '0, 1'b1);
      end
      esd_pkg::OP_ENQUEUE: begin
        if (pend_num >= esd_pkg::QueueDepth) begin
          push_rsp(esd_pkg::KIND_ENQ_ACK, 1'b0, '0, '0, '0, '0, '0, '0, 1'b1);
        end else begin
          pend_evt[pend_wr] = ev;
          pend_a[pend_wr]   = r.param_a;
          pend_b[pend_wr]   = r.param_b;
          pend_wr = (pend_wr + 1 >= esd_pkg::QueueDepth) ? 0 : pend_wr + 1;
          pend_num++;
          push_rsp(esd_pkg::KIND_ENQ_ACK, 1'b1, '0, '0, '0, '0, '0, '0, 1'b1);
        end
      end
      esd_pkg::OP_DRAIN: begin
        while (pend_num > 0) begin
          fan_out(pend_evt[pend_rd], pend_a[pend_rd], pend_b[pend_rd]);
          pend_rd = (pend_rd + 1 >= esd_pkg::QueueDepth) ? 0 : pend_rd + 1;
          pend_num--;
        end
        push_rsp(esd_pkg::KIND_DONE, 1'b1, '0, '0, '0, '0, '0, '0, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (error_count < 10) $display("mismatch on %s: expected %h, got %h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    esd_pkg::rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rsp_awaited.size() == 0) begin
        if (error_count < 10) $display("unexpected result: got %h", out_data_o);
        error_count++;
      end else begin
        want = rsp_awaited.pop_front();
        check_field("kind", want.kind, out_data_o.kind);
        check_field("ok", want.ok, out_data_o.ok);
        check_field("slot", want.slot, out_data_o.slot);
        check_field("out_event", want.out_event, out_data_o.out_event);
        check_field("out_param_a", want.out_param_a, out_data_o.out_param_a);
        check_field("out_param_b", want.out_param_b, out_data_o.out_param_b);
        check_field("out_target", want.out_target, out_data_o.out_target);
        check_field("out_tag", want.out_tag, out_data_o.out_tag);
        check_field("last", want.last, out_data_o.last);
      end
    end
  end

  initial begin : drive_ready
    int hold;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = idle_en ? $urandom_range(0, 12) : 0;
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // keep valid high across back-to-back requests; drop it only before a gap
  task automatic send_request(input esd_pkg::req_t r);
    int gap;
    gap = idle_en ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    route_request(r);
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (rsp_awaited.size() != 0);
  endtask

  task automatic test_table_ops();
    for (int i = 0; i < esd_pkg::Subscribers; i++) begin
      send_request(make_req(esd_pkg::OP_SUBSCRIBE, 8'hFF, 8'h00,
                            (i == 3) ? 32'h0 : ((i == 7) ? 32'hFFFF_FFFF : 32'h1000 + i),
                            (i == 0) ? 32'h0 : 32'hFFFF_FFFF - i, 32'h0, 32'h0));
    end
    send_request(make_req(esd_pkg::OP_SUBSCRIBE, 8'h00, 8'h00, 32'h1, 32'h2,
                          32'h0, 32'h0));
    send_request(make_req(esd_pkg::OP_PUBLISH, 8'hFF, 8'h00, 32'h0, 32'h0,
                          32'hFFFF_FFFF, 32'h0));
    send_request(make_req(esd_pkg::OP_PUBLISH, 8'h00, 8'h00, 32'h0, 32'h0,
                          32'h0, 32'hFFFF_FFFF));
    send_request(make_req(esd_pkg::OP_UNSUBSCRIBE, 8'h00, 8'hFF, 32'h0, 32'h0,
                          32'h0, 32'h0));
    send_request(make_req(esd_pkg::OP_UNSUBSCRIBE, 8'h00, 8'd3, 32'h0, 32'h0,
                          32'h0, 32'h0));
    send_request(make_req(esd_pkg::OP_UNSUBSCRIBE, 8'h00, 8'd3, 32'h0, 32'h0,
                          32'h0, 32'h0));
    send_request(make_req(esd_pkg::OP_SUBSCRIBE, 8'hFF, 8'h00, 32'hDEAD_0003,
                          32'h5A5A_A5A5, 32'h0, 32'h0));
  endtask

  task automatic test_queue_ops();
    for (int i = 0; i < esd_pkg::QueueDepth; i++) begin
      send_request(make_req(esd_pkg::OP_ENQUEUE, 8'hFF, 8'h00, 32'h0, 32'h0,
                            32'hA000_0000 + i, 32'hFFFF_FFF0 - i));
    end
    send_request(make_req(esd_pkg::OP_ENQUEUE, 8'hFF, 8'h00, 32'h0, 32'h0,
                          32'h1, 32'h2));
    send_request(make_req(esd_pkg::OP_DRAIN, 8'h00, 8'h00, 32'h0, 32'h0,
                          32'h0, 32'h0));
    send_request(make_req(esd_pkg::OP_DRAIN, 8'h00, 8'h00, 32'h0, 32'h0,
                          32'h0, 32'h0));
    send_request(make_req(esd_pkg::op_e'(OpUnusedLo), 8'hFF, 8'hFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_req(esd_pkg::op_e'(OpUnusedHi), 8'h00, 8'h00, 32'h0, 32'h0,
                          32'h0, 32'h0));
  endtask

  task automatic test_random_traffic(input int unsigned count);
    logic [7:0] ev_pool [4];
    esd_pkg::req_t r;
    int pick;
    for (int i = 0; i < 4; i++) ev_pool[i] = 8'($urandom_range(0, 255));
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25)      r.op = esd_pkg::OP_SUBSCRIBE;
      else if (pick < 45) r.op = esd_pkg::OP_UNSUBSCRIBE;
      else if (pick < 65) r.op = esd_pkg::OP_PUBLISH;
      else if (pick < 85) r.op = esd_pkg::OP_ENQUEUE;
      else if (pick < 95) r.op = esd_pkg::OP_DRAIN;
      else                r.op = esd_pkg::op_e'($urandom_range(OpUnusedLo, OpUnusedHi));
      r.event_id = ($urandom_range(0, 9) < 8) ? ev_pool[$urandom_range(0, 3)]
                                                : 8'($urandom_range(0, 255));
      r.handle   = ($urandom_range(0, 9) < 8)
                   ? 8'($urandom_range(0, esd_pkg::Subscribers - 1))
                   : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 19);
      r.target   = (pick < 3) ? 32'h0 : ((pick == 3) ? 32'hFFFF_FFFF : $urandom);
      r.tag      = $urandom;
      r.param_a  = $urandom;
      r.param_b  = $urandom;
      send_request(r);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_ops();
    test_queue_ops();
    wait_results_drained();
    test_random_traffic(300);
    wait_results_drained();
    idle_en = 1'b0;
    test_random_traffic(105);
    wait_results_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0 && rsp_awaited.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/esd_pkg.sv
hw/rtl/esd_ctrl.sv
hw/rtl/esd_datapath.sv
hw/rtl/event_subscription_dispatcher.sv
sim/testbench.sv
